[design/idq_pkg.sv]
// ----------------------------------------------------------------------------
// idq_pkg
// Shared defaults, operation codes and status codes for the indexed deque.
// ----------------------------------------------------------------------------
package idq_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int FUNC_BITS   = 3;
    localparam int STATUS_BITS = 2;

    typedef logic [FUNC_BITS-1:0]   func_t;
    typedef logic [STATUS_BITS-1:0] status_t;

    localparam func_t FUNC_PUSH_FRONT = 3'd0;
    localparam func_t FUNC_PUSH_BACK  = 3'd1;
    localparam func_t FUNC_POP_FRONT  = 3'd2;
    localparam func_t FUNC_POP_BACK   = 3'd3;
    localparam func_t FUNC_REMOVE     = 3'd4;

    localparam status_t STATUS_OK    = 2'd0;
    localparam status_t STATUS_EMPTY = 2'd1;
    localparam status_t STATUS_FULL  = 2'd2;

endpackage

[design/idq_ram.sv]
// ----------------------------------------------------------------------------
// idq_ram
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module idq_ram import idq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int PW        = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [PW-1:0]        wr_addr,
    input  logic [WORD_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [PW-1:0]        rd_addr,
    output logic [WORD_BITS-1:0] rd_data
);

    logic [WORD_BITS-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/idq_ctrl.sv]
// ----------------------------------------------------------------------------
// idq_ctrl
// Request sequencer: ring pointers, read-modify-write of the entry store,
// gap closing on remove and the registered result beat.
// ----------------------------------------------------------------------------
module idq_ctrl import idq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int PW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  func_t                func,
    input  logic [WORD_BITS-1:0] element,
    input  logic [PW-1:0]        position,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_BITS-1:0] taken_word,
    output status_t              status,
    output logic [CW-1:0]        count,
    output logic                 wr_en,
    output logic [PW-1:0]        wr_addr,
    output logic [WORD_BITS-1:0] wr_data,
    output logic                 rd_en,
    output logic [PW-1:0]        rd_addr,
    input  logic [WORD_BITS-1:0] rd_data
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_TAKE   = 2'd1;
    localparam logic [1:0] ST_SHIFT  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [PW-1:0]        front_reg, front_next;
    logic [CW-1:0]        fill_reg, fill_next;
    logic [CW-1:0]        idx_reg, idx_next;
    logic                 remove_reg, remove_next;
    logic [WORD_BITS-1:0] res_word_reg, res_word_next;
    status_t              res_status_reg, res_status_next;
    logic                 out_valid_reg, out_valid_next;
    logic [WORD_BITS-1:0] out_word_reg, out_word_next;
    status_t              out_status_reg, out_status_next;
    logic [CW-1:0]        out_count_reg, out_count_next;

    logic          full;
    logic          empty;
    logic [CW-1:0] pos_ext;
    logic [PW-1:0] front_dec;
    logic [PW-1:0] front_inc;
    logic          out_free;

    function automatic logic [PW-1:0] slot_of(input logic [PW-1:0] base,
                                              input logic [CW-1:0] k);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(k);
        if (sum >= (CW + 1)'(DEPTH))
        begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    assign full      = (fill_reg == CW'(DEPTH));
    assign empty     = (fill_reg == '0);
    assign pos_ext   = CW'(position);
    assign front_dec = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - 1'b1;
    assign front_inc = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + 1'b1;
    assign out_free  = !out_valid_reg || !out_stall;

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign taken_word = out_word_reg;
    assign status     = out_status_reg;
    assign count      = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        front_next      = front_reg;
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        remove_next     = remove_reg;
        res_word_next   = res_word_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_word_next   = out_word_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        wr_en           = 1'b0;
        wr_addr         = slot_of(front_reg, idx_reg);
        wr_data         = element;
        rd_en           = 1'b0;
        rd_addr         = front_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    res_word_next   = '0;
                    res_status_next = STATUS_OK;
                    remove_next     = 1'b0;
                    state_next      = ST_FINISH;
                    case (func)
                        FUNC_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                wr_addr    = front_dec;
                                front_next = front_dec;
                                fill_next  = fill_reg + 1'b1;
                            end
                        end
                        FUNC_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                res_status_next = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en     = 1'b1;
                                wr_addr   = slot_of(front_reg, fill_reg);
                                fill_next = fill_reg + 1'b1;
                            end
                        end
                        FUNC_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = front_reg;
                                front_next = front_inc;
                                fill_next  = fill_reg - 1'b1;
                                state_next = ST_TAKE;
                            end
                        end
                        FUNC_POP_BACK:
                        begin
                            if (empty)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                rd_addr    = slot_of(front_reg, fill_reg - 1'b1);
                                fill_next  = fill_reg - 1'b1;
                                state_next = ST_TAKE;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (pos_ext >= fill_reg)
                            begin
                                res_status_next = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en       = 1'b1;
                                rd_addr     = slot_of(front_reg, pos_ext);
                                fill_next   = fill_reg - 1'b1;
                                idx_next    = pos_ext;
                                remove_next = 1'b1;
                                state_next  = ST_TAKE;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_TAKE:
            begin
                res_word_next = rd_data;
                if (remove_reg && (idx_reg < fill_reg))
                begin
                    rd_en      = 1'b1;
                    rd_addr    = slot_of(front_reg, idx_reg + 1'b1);
                    state_next = ST_SHIFT;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                wr_en   = 1'b1;
                wr_addr = slot_of(front_reg, idx_reg);
                wr_data = rd_data;
                if ((idx_reg + 1'b1) < fill_reg)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = slot_of(front_reg, idx_reg + CW'(2));
                    idx_next = idx_reg + 1'b1;
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_word_next   = res_word_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = fill_reg;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            front_reg     <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg        <= idx_next;
        remove_reg     <= remove_next;
        res_word_reg   <= res_word_next;
        res_status_reg <= res_status_next;
        out_word_reg   <= out_word_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

endmodule

[design/indexed_deque.sv]
// A push writes the store, a pop reads it and takes the word, and remove at
// an index also shifts each entry behind the removed one forward (one store
// read and one store write a cycle); failed or unused requests write nothing.
// One request is in work at a time; a finished result waits in the output
// register while the next request is taken. Reset empties the store at
// once: fill and front pointer clear; entry contents are left as they are.
// ----------------------------------------------------------------------------
// indexed_deque
// Ring-buffer deque with push/pop at both ends and remove at an index.
// ----------------------------------------------------------------------------
module indexed_deque import idq_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int PW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int CW        = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  func_t                func,
    input  logic [WORD_BITS-1:0] element,
    input  logic [PW-1:0]        position,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_BITS-1:0] taken_word,
    output status_t              status,
    output logic [CW-1:0]        count
);

    logic                 wr_en;
    logic [PW-1:0]        wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic                 rd_en;
    logic [PW-1:0]        rd_addr;
    logic [WORD_BITS-1:0] rd_data;

    idq_ctrl #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .PW        (PW),
        .CW        (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .element    (element),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .taken_word (taken_word),
        .status     (status),
        .count      (count),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data)
    );

    idq_ram #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS),
        .PW        (PW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule
